/* hw/rtl/dgl_pkg.sv */
package dgl_pkg;

  localparam logic [31:0] Max32       = 32'hFFFF_FFFF;
  localparam logic [15:0] HalfLog2eQ16 = 16'd47274;
  localparam logic [63:0] Ln2Q32      = 64'd2977044472;
  localparam logic [31:0] NormReset   = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_MEAN_POS    = 3'd0,
    REG_MEAN_VEL    = 3'd1,
    REG_INV_VAR_POS = 3'd2,
    REG_INV_VAR_VEL = 3'd3,
    REG_NORM_FACTOR = 3'd4
  } dgl_reg_e;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
  } dgl_in_t;

  typedef struct packed {
    logic [31:0] likelihood;
    logic [31:0] distance_sq;
    logic        saturated;
  } dgl_out_t;

  // load enables of the three per-axis stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dgl_lane_en_t;

endpackage

/* hw/rtl/diag_gaussian_likelihood_6d.sv */
// Channel  Valid        Stall        Payload
// in       in_valid_i   in_stall_o   in_req_i  (dgl_pkg::dgl_in_t)
// out      out_valid_o  out_stall_i  out_req_o (dgl_pkg::dgl_out_t)
// cfg      APB write/read, 64-bit data, register i at byte address 8*i
//
// Ten register stages: one request per cycle while the pipeline is not stalled.
// Each stage holds its own valid bit and loads when empty or when the next stage
// loads, so requests fill empty stages while a finished result waits on out_stall_i.
// Reset clears valid bits and sets the configuration registers to their defaults.
module diag_gaussian_likelihood_6d #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dgl_pkg::dgl_in_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dgl_pkg::dgl_out_t out_req_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int unsigned NStg = 10;
  localparam int unsigned IdxW = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DepW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [DepW-1:0] DepthC = DepW'(EXP_TABLE_DEPTH);

  // 2^(-i/depth) in Q1.16 via a 12-term series of exp(-a)
  function automatic logic [16:0] frac_entry(input logic [63:0] i);
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] t;
    a = (i * dgl_pkg::Ln2Q32) / EXP_TABLE_DEPTH;
    s = 64'd1 << 32;
    t = 64'd1 << 32;
    t = ((t * a) >> 32) / 64'd1;  s = s - t;
    t = ((t * a) >> 32) / 64'd2;  s = s + t;
    t = ((t * a) >> 32) / 64'd3;  s = s - t;
    t = ((t * a) >> 32) / 64'd4;  s = s + t;
    t = ((t * a) >> 32) / 64'd5;  s = s - t;
    t = ((t * a) >> 32) / 64'd6;  s = s + t;
    t = ((t * a) >> 32) / 64'd7;  s = s - t;
    t = ((t * a) >> 32) / 64'd8;  s = s + t;
    t = ((t * a) >> 32) / 64'd9;  s = s - t;
    t = ((t * a) >> 32) / 64'd10; s = s + t;
    t = ((t * a) >> 32) / 64'd11; s = s - t;
    t = ((t * a) >> 32) / 64'd12; s = s + t;
    s = (s + 64'd32768) >> 16;
    return s[16:0];
  endfunction

  logic [16:0] tab_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [16:0] Val = frac_entry(64'(g));
    assign tab_rom[g] = Val;
  end

  // configuration
  logic [47:0] mean_pos_q, mean_vel_q, inv_var_pos_q, inv_var_vel_q;
  logic [31:0] norm_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_pos_q    <= '0;
      mean_vel_q    <= '0;
      inv_var_pos_q <= '0;
      inv_var_vel_q <= '0;
      norm_q        <= dgl_pkg::NormReset;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        dgl_pkg::REG_MEAN_POS:    mean_pos_q    <= pwdata[47:0];
        dgl_pkg::REG_MEAN_VEL:    mean_vel_q    <= pwdata[47:0];
        dgl_pkg::REG_INV_VAR_POS: inv_var_pos_q <= pwdata[47:0];
        dgl_pkg::REG_INV_VAR_VEL: inv_var_vel_q <= pwdata[47:0];
        dgl_pkg::REG_NORM_FACTOR: norm_q        <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      dgl_pkg::REG_MEAN_POS:    prdata = {16'd0, mean_pos_q};
      dgl_pkg::REG_MEAN_VEL:    prdata = {16'd0, mean_vel_q};
      dgl_pkg::REG_INV_VAR_POS: prdata = {16'd0, inv_var_pos_q};
      dgl_pkg::REG_INV_VAR_VEL: prdata = {16'd0, inv_var_vel_q};
      dgl_pkg::REG_NORM_FACTOR: prdata = {32'd0, norm_q};
      default:                  prdata = '0;
    endcase
  end

  // pipeline flow control
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] ld;

  always_comb begin
    ld[NStg-1] = !v_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[NStg-1];

  // stages 0..2: per-axis weighted squares
  logic signed [15:0] xs [6];
  logic [39:0]        terms [6];
  dgl_pkg::dgl_lane_en_t lane_en;

  assign xs[0] = in_req_i.pos_x;
  assign xs[1] = in_req_i.pos_y;
  assign xs[2] = in_req_i.pos_z;
  assign xs[3] = in_req_i.vel_x;
  assign xs[4] = in_req_i.vel_y;
  assign xs[5] = in_req_i.vel_z;

  assign lane_en.s1 = ld[0];
  assign lane_en.s2 = ld[1];
  assign lane_en.s3 = ld[2];

  for (genvar g = 0; g < 6; g++) begin : g_lane
    logic [15:0] mean_l;
    logic [15:0] w_l;
    if (g < 3) begin : g_pos
      assign mean_l = mean_pos_q[16*g +: 16];
      assign w_l    = inv_var_pos_q[16*g +: 16];
    end else begin : g_vel
      assign mean_l = mean_vel_q[16*(g-3) +: 16];
      assign w_l    = inv_var_vel_q[16*(g-3) +: 16];
    end
    dgl_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (lane_en),
      .x_i    (xs[g]),
      .mean_i (mean_l),
      .w_i    (w_l),
      .term_o (terms[g])
    );
  end

  // stage 3: pair sums
  logic [40:0] psum_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      for (int j = 0; j < 3; j++) begin
        psum_q[j] <= {1'b0, terms[2*j]} + {1'b0, terms[2*j+1]};
      end
    end
  end

  // stage 4: distance with saturation
  logic [42:0] total;
  logic [31:0] d4_q;

  assign total = {2'd0, psum_q[0]} + {2'd0, psum_q[1]} + {2'd0, psum_q[2]};

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      d4_q <= (total[42:32] != '0) ? dgl_pkg::Max32 : total[31:0];
    end
  end

  // stage 5: exponent in base 2
  logic [47:0] e_full;
  logic [31:0] e5_q, d5_q;

  assign e_full = d4_q * dgl_pkg::HalfLog2eQ16;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      e5_q <= e_full[47:16];
      d5_q <= d4_q;
    end
  end

  // stage 6: table index
  logic [15+DepW:0] idx_full;
  logic [IdxW-1:0]  idx6_q;
  logic [3:0]       n6_q;
  logic             zero6_q;
  logic [31:0]      d6_q;

  assign idx_full = e5_q[15:0] * DepthC;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      idx6_q  <= idx_full[16 +: IdxW];
      n6_q    <= e5_q[19:16];
      zero6_q <= (e5_q[31:20] != '0);
      d6_q    <= d5_q;
    end
  end

  // stage 7: table read, deep tail forces zero
  logic [16:0] tab7_q;
  logic [3:0]  n7_q;
  logic [31:0] d7_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      tab7_q <= zero6_q ? 17'd0 : tab_rom[idx6_q];
      n7_q   <= n6_q;
      d7_q   <= d6_q;
    end
  end

  // stage 8: scale by normalization
  logic [48:0] prod8_q;
  logic [3:0]  n8_q;
  logic [31:0] d8_q;

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      prod8_q <= tab7_q * norm_q;
      n8_q    <= n7_q;
      d8_q    <= d7_q;
    end
  end

  // stage 9: shift, saturate, flag
  logic [32:0] lik_sh;
  logic [31:0] lik;
  dgl_pkg::dgl_out_t out_q;

  assign lik_sh = prod8_q[48:16] >> n8_q;
  assign lik    = lik_sh[32] ? dgl_pkg::Max32 : lik_sh[31:0];

  always_ff @(posedge clk_i) begin
    if (ld[9]) begin
      out_q.likelihood  <= lik;
      out_q.distance_sq <= d8_q;
      out_q.saturated   <= (d8_q == dgl_pkg::Max32) || (lik == dgl_pkg::Max32);
    end
  end

  assign out_req_o = out_q;

endmodule

/* hw/rtl/dgl_lane.sv */
module dgl_lane (
  input  logic                 clk_i,
  input  dgl_pkg::dgl_lane_en_t en_i,
  input  logic signed [15:0]   x_i,
  input  logic signed [15:0]   mean_i,
  input  logic [15:0]          w_i,
  output logic [39:0]          term_o
);

  logic [16:0] diff;
  logic [16:0] diff_neg;
  logic [15:0] mag_d, mag_q;
  logic [31:0] sq_d, sq_q;
  logic [47:0] wsq;
  logic [39:0] term_q;

  // |x - mean| never exceeds 65535
  assign diff     = {x_i[15], x_i} - {mean_i[15], mean_i};
  assign diff_neg = 17'd0 - diff;
  assign mag_d    = diff[16] ? diff_neg[15:0] : diff[15:0];
  assign sq_d     = mag_q * mag_q;
  assign wsq      = sq_q * w_i;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      mag_q <= mag_d;
    end
    if (en_i.s2) begin
      sq_q <= sq_d;
    end
    if (en_i.s3) begin
      term_q <= wsq[47:8];
    end
  end

  assign term_o = term_q;

endmodule
